[rtl/stb_pkg.sv]
// Shared constants, operation codes and the control bundle for the timer bank.
`default_nettype none
package stb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIME_BITS  = 48;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam int OP_W  = 3;
  localparam int TID_W = 3;
  localparam int DUR_W = 32;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_START   = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic exec;   // apply the captured item, register its result
  } stb_cmd_t;

endpackage
`default_nettype wire

[rtl/soft_timer_bank_top.sv]
// Top level of the one-shot timer bank: controller plus datapath.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_op, in_timer_index, in_duration
//   out     | output    | out_valid/out_stall| out_running, out_elapsed
//
// One beat in gives one beat out; after acceptance the controller steps through ST_EXEC to ST_OUT.
// The capture/execute sequence of the controller takes no new beat while one
// is in execution; a new beat is taken as the previous result leaves.
// Synchronous active-low reset clears the counter, all per-timer flags and lengths.
// A stalled result holds, and input stays stalled until it is taken.
`default_nettype none
module soft_timer_bank_top (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire [stb_pkg::OP_W-1:0]   in_op,
  input  wire [stb_pkg::TID_W-1:0]  in_timer_index,
  input  wire [stb_pkg::DUR_W-1:0]  in_duration,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      out_running,
  output logic                      out_elapsed
);

  stb_pkg::stb_cmd_t cmd;

  stb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  stb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_timer_index (in_timer_index),
    .in_duration    (in_duration),
    .out_running    (out_running),
    .out_elapsed    (out_elapsed)
  );

  // no input beat while a stalled result is pending
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && !in_stall && out_valid && out_stall))
    else $error("input beat taken over a stalled result");

  // result is absent during the ST_EXEC state that follows acceptance and shows up in ST_OUT
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid ##1 out_valid)
    else $error("result timing broken");

  // a timer is never both running and elapsed
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_running && out_elapsed))
    else $error("running and elapsed both set");

endmodule
`default_nettype wire

[rtl/stb_ctrl.sv]
// Controller: sequences capture, execute and result hand-off.
`default_nettype none
module stb_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  output stb_pkg::stb_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_acc;
  logic       out_acc;

  // a new beat may land in the same cycle the pending result leaves
  assign out_valid = (state_r == ST_OUT);
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || out_acc);
  assign in_acc    = in_valid && !in_stall;

  assign cmd.load = in_acc;
  assign cmd.exec = (state_r == ST_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (in_acc)       state_nxt = ST_EXEC;
        else if (out_acc) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/stb_dp.sv]
// Datapath: tick counter, per-timer flags, lengths and deadlines.
`default_nettype none
module stb_dp (
  input  wire                          clk,
  input  wire                          rst_n,
  input  stb_pkg::stb_cmd_t            cmd,
  input  wire [stb_pkg::OP_W-1:0]      in_op,
  input  wire [stb_pkg::TID_W-1:0]     in_timer_index,
  input  wire [stb_pkg::DUR_W-1:0]     in_duration,
  output logic                         out_running,
  output logic                         out_elapsed
);

  logic [stb_pkg::OP_W-1:0]      op_r;
  logic [stb_pkg::IDX_W-1:0]     idx_r;
  logic                          hit_r;
  logic [stb_pkg::DUR_W-1:0]     dur_r;

  logic [stb_pkg::TIME_BITS-1:0] now_r;
  logic [stb_pkg::NUM_TIMERS-1:0] run_r;
  logic [stb_pkg::NUM_TIMERS-1:0] done_r;
  logic [stb_pkg::DUR_W-1:0]     len_r      [stb_pkg::NUM_TIMERS];
  logic [stb_pkg::TIME_BITS-1:0] deadline_r [stb_pkg::NUM_TIMERS];

  logic                          run_o_r, done_o_r;

  logic [stb_pkg::DUR_W-1:0]     arm_len;
  logic [stb_pkg::TIME_BITS-1:0] deadline_sum;
  logic                          expired;
  logic                          run_nxt, done_nxt;
  logic                          arm;
  logic                          write_flags;

  assign arm_len      = (op_r == stb_pkg::OP_START) ? dur_r : len_r[idx_r];
  assign deadline_sum = now_r + stb_pkg::TIME_BITS'(arm_len);
  assign expired      = (now_r >= deadline_r[idx_r]);

  always_comb begin
    run_nxt     = run_r[idx_r];
    done_nxt    = done_r[idx_r];
    arm         = 1'b0;
    write_flags = 1'b0;
    unique case (op_r) inside
      stb_pkg::OP_START, stb_pkg::OP_RESTART: begin
        arm         = 1'b1;
        run_nxt     = 1'b1;
        done_nxt    = 1'b0;
        write_flags = 1'b1;
      end
      stb_pkg::OP_STOP: begin
        run_nxt     = 1'b0;
        done_nxt    = 1'b0;
        write_flags = 1'b1;
      end
      stb_pkg::OP_QUERY: begin
        if (run_r[idx_r] && expired) begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
        end
        write_flags = 1'b1;
      end
      default: begin
        // tick and unused codes leave the timer alone
      end
    endcase
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      idx_r <= stb_pkg::IDX_W'(in_timer_index);
      hit_r <= (32'(in_timer_index) < 32'(stb_pkg::NUM_TIMERS));
      dur_r <= in_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      run_r  <= '0;
      done_r <= '0;
      for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) len_r[i] <= '0;
    end else if (cmd.exec) begin
      if (op_r == stb_pkg::OP_TICK) now_r <= now_r + stb_pkg::TIME_BITS'(1);
      if (hit_r && write_flags) begin
        run_r[idx_r]  <= run_nxt;
        done_r[idx_r] <= done_nxt;
      end
      if (hit_r && (op_r == stb_pkg::OP_START)) len_r[idx_r] <= dur_r;
    end
  end

  // deadlines are only looked at while running, i.e. after an arm wrote them
  always_ff @(posedge clk) begin
    if (cmd.exec && hit_r && arm) deadline_r[idx_r] <= deadline_sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      run_o_r  <= hit_r && run_nxt;
      done_o_r <= hit_r && done_nxt;
    end
  end

  assign out_running = run_o_r;
  assign out_elapsed = done_o_r;

endmodule
`default_nettype wire
